FILE: design/dma_buffer_list_manager_defines.svh
// Assertion macros shared by the checker of the DMA buffer-list manager.
// No dependencies.
`ifndef DMA_BUFFER_LIST_MANAGER_DEFINES_SVH
`define DMA_BUFFER_LIST_MANAGER_DEFINES_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define DBL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define DBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/dbl_pkg.sv
// Types and constants of the DMA buffer-list manager.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package dbl_pkg;

  localparam int NBUF        = 64;
  localparam int NBUF_W      = 6;
  localparam int LINK_W      = 7;
  localparam int CNT_W       = 7;
  localparam int COUNT_WIDTH = 32;

  localparam logic [LINK_W-1:0] NIL   = 7'h7F;
  localparam logic [LINK_W-1:0] DUMMY = 7'd64;

  typedef logic [1:0] list_id_t;
  localparam list_id_t LST_FREE  = 2'd0;
  localparam list_id_t LST_READY = 2'd1;
  localparam list_id_t LST_HOT   = 2'd2;
  localparam list_id_t LST_GRAB  = 2'd3;

  typedef logic [2:0] tag_t;
  localparam tag_t TAG_NONE  = 3'd0;
  localparam tag_t TAG_FREE  = 3'd1;
  localparam tag_t TAG_READY = 3'd2;
  localparam tag_t TAG_HOT   = 3'd3;
  localparam tag_t TAG_GRAB  = 3'd4;
  localparam tag_t TAG_LOCK  = 3'd5;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_REGISTER = 3'd0;
  localparam mode_t MODE_REMOVE   = 3'd1;
  localparam mode_t MODE_FRAME    = 3'd2;
  localparam mode_t MODE_QUEUE    = 3'd3;
  localparam mode_t MODE_NEXT_BLK = 3'd4;
  localparam mode_t MODE_LAST_BLK = 3'd5;
  localparam mode_t MODE_UNBLOCK  = 3'd6;
  localparam mode_t MODE_START    = 3'd7;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_STATUS  = 2'd0;
  localparam kind_t KIND_QUEUED  = 2'd1;
  localparam kind_t KIND_DONE    = 2'd2;
  localparam kind_t KIND_BLOCKED = 2'd3;

  typedef logic [1:0] stat_code_t;
  localparam stat_code_t ST_OK      = 2'd0;
  localparam stat_code_t ST_INVALID = 2'd1;
  localparam stat_code_t ST_BUSY    = 2'd2;
  localparam stat_code_t ST_NONE    = 2'd3;

  localparam logic [1:0] ACQ_HANDSHAKE = 2'd1;
  localparam logic [1:0] ACQ_SELECTIVE = 2'd2;

  localparam logic [1:0] CFG_ACQ_MODE    = 2'd0;
  localparam logic [1:0] CFG_FIFO_DEPTH  = 2'd1;
  localparam logic [1:0] CFG_NUM_BUFFERS = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LATCH, OP_HEAD, OP_LINKRD, OP_UNLINK, OP_APPEND,
    OP_UNTAG, OP_LOCK, OP_UNLOCK, OP_CALC, OP_WALKDEC, OP_SETDUMMY,
    OP_START, OP_FD_INACT, OP_LOST, OP_FD_DONE
  } dp_op_t;

  typedef enum logic [1:0] {ISEL_ZERO, ISEL_IN, ISEL_NODE} isel_t;

  typedef struct packed {
    dp_op_t     op;
    list_id_t   list;
    logic       emit;
    kind_t      kind;
    isel_t      isel;
    stat_code_t st;
    logic       ts_en;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    tag_t       tag;
    logic       idx_ok;
    logic       active;
    logic       hot_empty;
    logic       grab_empty;
    logic       grab_one;
    logic       node_dummy;
    logic       walk_zero;
    logic       walk_dummy;
    logic       walk_did;
    logic       ub_walk;
    logic       clr_done;
    logic [1:0] acq_mode;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RM_UNL, S_RM_TAG, S_FD_UNL, S_FD_MOV,
    S_FD_DONE, S_LB_CHK, S_LB_UNL, S_LB_APP, S_BL_UNL, S_BL_LOCK, S_UB_UNL,
    S_UB_APP, S_UB_CHK, S_ST_CALC, S_WALK, S_W_UNL, S_W_APP, S_W_EMIT,
    S_FIN_OK, S_FIN_NONE, S_FIN_FD, S_FIN_BL
  } state_t;

endpackage
`default_nettype wire

FILE: design/dbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: design/dbl_datapath.sv
// Datapath of the buffer-list manager: link and tag memories, list heads,
// tails and counts, frame counters, configuration and result registers.
// Depends on dbl_pkg and dbl_ram.
`timescale 1ns / 1ps
`default_nettype none
module dbl_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [dbl_pkg::NBUF_W-1:0]       in_buffer_index,
  input  wire logic [dbl_pkg::COUNT_WIDTH-1:0]  in_transfer_count,
  input  wire logic [31:0]                      in_timestamp,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [6:0]                       cfg_data,
  input  wire dbl_pkg::dp_cmd_t                 cmd,
  output dbl_pkg::dp_stat_t                     stat,
  output logic                                  out_valid,
  output logic [1:0]                            out_result_kind,
  output logic [6:0]                            out_index,
  output logic [1:0]                            out_status,
  output logic [31:0]                           out_timestamp,
  output logic [6:0]                            out_ready_now,
  output logic [6:0]                            out_hot_now,
  output logic [31:0]                           out_lost_now,
  output logic                                  out_last
);
  import dbl_pkg::*;

  localparam int PAD = COUNT_WIDTH - CNT_W;

  logic [NBUF_W-1:0]      idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] tc_r, tc_nxt;
  logic [31:0]            ts_r, ts_nxt;
  logic [LINK_W-1:0]      node_r, node_nxt;
  logic [LINK_W-1:0]      head_r [4];
  logic [LINK_W-1:0]      head_nxt [4];
  logic [LINK_W-1:0]      tail_r [4];
  logic [LINK_W-1:0]      tail_nxt [4];
  logic [CNT_W-1:0]       cnt_r [4];
  logic [CNT_W-1:0]       cnt_nxt [4];
  logic [CNT_W-1:0]       lock_r, lock_nxt;
  logic [COUNT_WIDTH-1:0] lost_r, lost_nxt;
  logic [COUNT_WIDTH-1:0] fl_r, fl_nxt;
  logic                   active_r, active_nxt;
  logic [CNT_W-1:0]       walk_n_r, walk_n_nxt;
  logic                   walk_dum_r, walk_dum_nxt;
  logic                   walk_did_r, walk_did_nxt;
  logic [CNT_W-1:0]       pred_rdy_r, pred_rdy_nxt;
  logic [CNT_W-1:0]       pred_hot_r, pred_hot_nxt;
  logic [NBUF_W-1:0]      clr_r, clr_nxt;
  logic [1:0]             acq_r, acq_nxt;
  logic [5:0]             depth_r, depth_nxt;
  logic [6:0]             num_r, num_nxt;

  // Memory ports.
  logic              nx_we, pv_we, nx_re;
  logic [LINK_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd, lk_ra, nx_rd, pv_rd;
  logic              tg_we, tg_re;
  logic [NBUF_W-1:0] tg_wa;
  tag_t              tg_wd, tg_rd;

  // Unlink, append and walk arithmetic.
  logic [LINK_W-1:0]      p_v, q_v, t_v;
  logic [CNT_W-1:0]       hot, rdy, room, n1, n_v, calc_n;
  logic [COUNT_WIDTH-1:0] hot_ext, rdy_ext, diff, fl_dec;
  logic                   fl_le, hs_empty, calc_dummy;

  dbl_ram #(.WIDTH(LINK_W), .DEPTH(NBUF + 1)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .re(nx_re), .raddr(lk_ra), .rdata(nx_rd));

  dbl_ram #(.WIDTH(LINK_W), .DEPTH(NBUF + 1)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .re(nx_re), .raddr(lk_ra), .rdata(pv_rd));

  dbl_ram #(.WIDTH(3), .DEPTH(NBUF)) u_tag (
    .clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd),
    .re(tg_re), .raddr(in_buffer_index), .rdata(tg_rd));

  always_comb begin
    hot      = cnt_r[LST_HOT];
    rdy      = cnt_r[LST_READY];
    hot_ext  = {{PAD{1'b0}}, hot};
    rdy_ext  = {{PAD{1'b0}}, rdy};
    diff     = fl_r - hot_ext;
    fl_le    = fl_r <= hot_ext;
    room     = ({1'b0, depth_r} > hot) ? ({1'b0, depth_r} - hot) : '0;
    n1       = (diff < rdy_ext) ? diff[CNT_W-1:0] : rdy;
    n_v      = (room < n1) ? room : n1;
    hs_empty = (acq_r == ACQ_HANDSHAKE) && (rdy == '0);
    calc_dummy = !fl_le && hs_empty && (hot == '0) && active_r;
    calc_n   = (fl_le || hs_empty) ? '0 : n_v;
    fl_dec   = fl_r - 1'b1;
    p_v = (node_r == head_r[cmd.list]) ? NIL : pv_rd;
    q_v = (node_r == tail_r[cmd.list]) ? NIL : nx_rd;
    t_v = tail_r[cmd.list];
  end

  always_comb begin
    idx_nxt = idx_r;  tc_nxt = tc_r;  ts_nxt = ts_r;  node_nxt = node_r;
    head_nxt = head_r;  tail_nxt = tail_r;  cnt_nxt = cnt_r;
    lock_nxt = lock_r;  lost_nxt = lost_r;  fl_nxt = fl_r;  active_nxt = active_r;
    walk_n_nxt = walk_n_r;  walk_dum_nxt = walk_dum_r;  walk_did_nxt = walk_did_r;
    pred_rdy_nxt = pred_rdy_r;  pred_hot_nxt = pred_hot_r;  clr_nxt = clr_r;
    acq_nxt = acq_r;  depth_nxt = depth_r;  num_nxt = num_r;
    nx_we = 1'b0;  nx_wa = '0;  nx_wd = '0;
    pv_we = 1'b0;  pv_wa = '0;  pv_wd = '0;
    nx_re = 1'b0;  lk_ra = node_r;
    tg_we = 1'b0;  tg_wa = node_r[NBUF_W-1:0];  tg_wd = TAG_NONE;  tg_re = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_ACQ_MODE:    acq_nxt   = cfg_data[1:0];
        CFG_FIFO_DEPTH:  depth_nxt = cfg_data[5:0];
        CFG_NUM_BUFFERS: num_nxt   = cfg_data;
        default: ;
      endcase
    end

    case (cmd.op)
      OP_CLR: begin
        tg_we   = 1'b1;
        tg_wa   = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      OP_LATCH: begin
        idx_nxt  = in_buffer_index;
        node_nxt = {1'b0, in_buffer_index};
        tc_nxt   = in_transfer_count;
        ts_nxt   = in_timestamp;
        tg_re    = 1'b1;
      end
      OP_HEAD: begin
        node_nxt = head_r[cmd.list];
        lk_ra    = head_r[cmd.list];
        nx_re    = 1'b1;
      end
      OP_LINKRD: nx_re = 1'b1;
      OP_UNLINK: begin
        if (p_v != NIL) begin
          nx_we = 1'b1;  nx_wa = p_v;  nx_wd = q_v;
        end else begin
          head_nxt[cmd.list] = q_v;
        end
        if (q_v != NIL) begin
          pv_we = 1'b1;  pv_wa = q_v;  pv_wd = p_v;
        end else begin
          tail_nxt[cmd.list] = p_v;
        end
        cnt_nxt[cmd.list] = cnt_r[cmd.list] - 1'b1;
      end
      OP_APPEND: begin
        pv_we = 1'b1;  pv_wa = node_r;  pv_wd = t_v;
        if (t_v != NIL) begin
          nx_we = 1'b1;  nx_wa = t_v;  nx_wd = node_r;
        end else begin
          head_nxt[cmd.list] = node_r;
        end
        tail_nxt[cmd.list] = node_r;
        cnt_nxt[cmd.list]  = cnt_r[cmd.list] + 1'b1;
        tg_we = (node_r != DUMMY);
        tg_wd = {1'b0, cmd.list} + 3'd1;
      end
      OP_UNTAG: tg_we = 1'b1;
      OP_LOCK: begin
        lock_nxt = lock_r + 1'b1;
        tg_we    = 1'b1;
        tg_wd    = TAG_LOCK;
      end
      OP_UNLOCK: lock_nxt = lock_r - 1'b1;
      OP_CALC: begin
        walk_n_nxt   = calc_n;
        walk_dum_nxt = calc_dummy;
        walk_did_nxt = (calc_n != '0) || calc_dummy;
        pred_rdy_nxt = rdy - calc_n;
        pred_hot_nxt = hot + calc_n + {{(CNT_W-1){1'b0}}, calc_dummy};
      end
      OP_WALKDEC: begin
        if (walk_dum_r) begin
          walk_dum_nxt = 1'b0;
        end else begin
          walk_n_nxt = walk_n_r - 1'b1;
        end
      end
      OP_SETDUMMY: node_nxt = DUMMY;
      OP_START: begin
        fl_nxt     = tc_r;
        active_nxt = tc_r != '0;
      end
      OP_FD_INACT: begin
        lost_nxt = lost_r + 1'b1;
        fl_nxt   = '0;
      end
      OP_LOST: lost_nxt = lost_r + 1'b1;
      OP_FD_DONE: begin
        if (node_r == DUMMY) begin
          lost_nxt = lost_r + 1'b1;
        end
        fl_nxt = fl_dec;
        if (fl_dec == '0) begin
          active_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.tag        = tg_rd;
    stat.idx_ok     = {1'b0, idx_r} < num_r;
    stat.active     = active_r;
    stat.hot_empty  = cnt_r[LST_HOT] == '0;
    stat.grab_empty = cnt_r[LST_GRAB] == '0;
    stat.grab_one   = head_r[LST_GRAB] == tail_r[LST_GRAB];
    stat.node_dummy = node_r == DUMMY;
    stat.walk_zero  = walk_n_r == '0;
    stat.walk_dummy = walk_dum_r;
    stat.walk_did   = walk_did_r;
    stat.ub_walk    = (cnt_r[LST_HOT] <= CNT_W'(1)) && (cnt_r[LST_READY] != '0);
    stat.clr_done   = clr_r == NBUF_W'(NBUF - 1);
    stat.acq_mode   = acq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
        cnt_r[i]  <= '0;
      end
      lock_r     <= '0;
      lost_r     <= '0;
      fl_r       <= '0;
      active_r   <= 1'b0;
      walk_n_r   <= '0;
      walk_dum_r <= 1'b0;
      walk_did_r <= 1'b0;
      clr_r      <= '0;
      acq_r      <= 2'd0;
      depth_r    <= 6'd16;
      num_r      <= 7'd64;
      out_valid  <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      lock_r     <= lock_nxt;
      lost_r     <= lost_nxt;
      fl_r       <= fl_nxt;
      active_r   <= active_nxt;
      walk_n_r   <= walk_n_nxt;
      walk_dum_r <= walk_dum_nxt;
      walk_did_r <= walk_did_nxt;
      clr_r      <= clr_nxt;
      acq_r      <= acq_nxt;
      depth_r    <= depth_nxt;
      num_r      <= num_nxt;
      out_valid  <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    tc_r       <= tc_nxt;
    ts_r       <= ts_nxt;
    node_r     <= node_nxt;
    pred_rdy_r <= pred_rdy_nxt;
    pred_hot_r <= pred_hot_nxt;
    if (cmd.emit) begin
      out_result_kind <= cmd.kind;
      case (cmd.isel)
        ISEL_IN:   out_index <= {1'b0, idx_r};
        ISEL_NODE: out_index <= node_r;
        default:   out_index <= '0;
      endcase
      out_status    <= cmd.st;
      out_timestamp <= cmd.ts_en ? ts_r : '0;
      out_ready_now <= (cmd.kind == KIND_QUEUED) ? pred_rdy_r : cnt_r[LST_READY];
      out_hot_now   <= (cmd.kind == KIND_QUEUED) ? pred_hot_r : cnt_r[LST_HOT];
      out_lost_now  <= lost_r;
      out_last      <= cmd.last;
    end
  end
endmodule
`default_nettype wire

FILE: design/dbl_ctrl.sv
// Controller of the buffer-list manager: one state machine that sequences
// datapath operations for each event. Depends on dbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [2:0]        in_mode,
  input  wire dbl_pkg::dp_stat_t stat,
  output dbl_pkg::dp_cmd_t       cmd,
  output logic                   busy
);
  import dbl_pkg::*;

  state_t st_r, st_nxt;
  mode_t  mode_r, mode_nxt;

  function automatic dp_cmd_t mk(dp_op_t op, list_id_t lst);
    dp_cmd_t c;
    c = '0;
    c.op = op;
    c.list = lst;
    return c;
  endfunction

  function automatic dp_cmd_t em(kind_t k, isel_t s, stat_code_t code, logic ts,
                                 logic lst);
    dp_cmd_t c;
    c = '0;
    c.op = OP_NOP;
    c.emit = 1'b1;
    c.kind = k;
    c.isel = s;
    c.st = code;
    c.ts_en = ts;
    c.last = lst;
    return c;
  endfunction

  function automatic list_id_t dest(logic [1:0] acq);
    list_id_t d;
    d = LST_READY;
    if (acq == ACQ_HANDSHAKE) begin
      d = LST_GRAB;
    end else if (acq == ACQ_SELECTIVE) begin
      d = LST_FREE;
    end
    return d;
  endfunction

  always_comb begin
    st_nxt   = st_r;
    mode_nxt = mode_r;
    cmd      = mk(OP_NOP, LST_FREE);
    busy     = st_r != S_IDLE;
    case (st_r)
      S_CLEAR: begin
        cmd = mk(OP_CLR, LST_FREE);
        if (stat.clr_done) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd      = mk(OP_LATCH, LST_FREE);
          mode_nxt = in_mode;
          st_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt = S_IDLE;
        case (mode_r)
          MODE_REGISTER: begin
            if (!stat.idx_ok) begin
              cmd = em(KIND_STATUS, ISEL_IN, ST_INVALID, 1'b0, 1'b1);
            end else if (stat.tag != TAG_NONE) begin
              cmd = em(KIND_STATUS, ISEL_IN, ST_BUSY, 1'b0, 1'b1);
            end else begin
              cmd    = mk(OP_APPEND, LST_FREE);
              st_nxt = S_FIN_OK;
            end
          end
          MODE_REMOVE: begin
            if (!stat.idx_ok || stat.tag == TAG_NONE || stat.tag > TAG_LOCK) begin
              cmd = em(KIND_STATUS, ISEL_IN, ST_INVALID, 1'b0, 1'b1);
            end else if (stat.active && stat.tag == TAG_HOT) begin
              cmd = em(KIND_STATUS, ISEL_IN, ST_BUSY, 1'b0, 1'b1);
            end else if (stat.tag == TAG_LOCK) begin
              cmd    = mk(OP_UNLOCK, LST_FREE);
              st_nxt = S_RM_TAG;
            end else begin
              cmd    = mk(OP_LINKRD, LST_FREE);
              st_nxt = S_RM_UNL;
            end
          end
          MODE_FRAME: begin
            if (!stat.active) begin
              cmd    = mk(OP_FD_INACT, LST_FREE);
              st_nxt = S_FIN_NONE;
            end else if (stat.hot_empty) begin
              cmd    = mk(OP_LOST, LST_FREE);
              st_nxt = S_FIN_NONE;
            end else begin
              cmd    = mk(OP_HEAD, LST_HOT);
              st_nxt = S_FD_UNL;
            end
          end
          MODE_QUEUE: begin
            cmd    = mk(OP_CALC, LST_FREE);
            st_nxt = S_WALK;
          end
          MODE_NEXT_BLK, MODE_LAST_BLK: begin
            if (stat.grab_empty) begin
              cmd = em(KIND_STATUS, ISEL_ZERO, ST_NONE, 1'b0, 1'b1);
            end else if (mode_r == MODE_LAST_BLK) begin
              st_nxt = S_LB_CHK;
            end else begin
              cmd    = mk(OP_HEAD, LST_GRAB);
              st_nxt = S_BL_UNL;
            end
          end
          MODE_UNBLOCK: begin
            if (!stat.idx_ok || stat.tag == TAG_NONE || stat.tag > TAG_LOCK) begin
              cmd = em(KIND_STATUS, ISEL_IN, ST_INVALID, 1'b0, 1'b1);
            end else if (stat.tag == TAG_GRAB) begin
              cmd    = mk(OP_LINKRD, LST_FREE);
              st_nxt = S_UB_UNL;
            end else if (stat.tag == TAG_LOCK) begin
              cmd    = mk(OP_UNLOCK, LST_FREE);
              st_nxt = S_UB_APP;
            end else begin
              cmd = em(KIND_STATUS, ISEL_IN, ST_OK, 1'b0, 1'b1);
            end
          end
          default: begin
            cmd    = mk(OP_START, LST_FREE);
            st_nxt = S_ST_CALC;
          end
        endcase
      end
      S_RM_UNL: begin
        cmd    = mk(OP_UNLINK, list_id_t'(stat.tag - 3'd1));
        st_nxt = S_RM_TAG;
      end
      S_RM_TAG: begin
        cmd    = mk(OP_UNTAG, LST_FREE);
        st_nxt = S_FIN_OK;
      end
      S_FD_UNL: begin
        cmd    = mk(OP_UNLINK, LST_HOT);
        st_nxt = S_FD_MOV;
      end
      S_FD_MOV: begin
        if (stat.node_dummy) begin
          cmd    = mk(OP_FD_DONE, LST_FREE);
          st_nxt = S_FIN_FD;
        end else begin
          cmd    = mk(OP_APPEND, dest(stat.acq_mode));
          st_nxt = S_FD_DONE;
        end
      end
      S_FD_DONE: begin
        cmd    = mk(OP_FD_DONE, LST_FREE);
        st_nxt = S_FIN_FD;
      end
      S_LB_CHK: begin
        cmd    = mk(OP_HEAD, LST_GRAB);
        st_nxt = stat.grab_one ? S_BL_UNL : S_LB_UNL;
      end
      S_LB_UNL: begin
        cmd    = mk(OP_UNLINK, LST_GRAB);
        st_nxt = S_LB_APP;
      end
      S_LB_APP: begin
        cmd    = mk(OP_APPEND, LST_READY);
        st_nxt = S_LB_CHK;
      end
      S_BL_UNL: begin
        cmd    = mk(OP_UNLINK, LST_GRAB);
        st_nxt = S_BL_LOCK;
      end
      S_BL_LOCK: begin
        cmd    = mk(OP_LOCK, LST_FREE);
        st_nxt = S_FIN_BL;
      end
      S_UB_UNL: begin
        cmd    = mk(OP_UNLINK, LST_GRAB);
        st_nxt = S_UB_APP;
      end
      S_UB_APP: begin
        cmd    = mk(OP_APPEND, LST_READY);
        st_nxt = S_UB_CHK;
      end
      S_UB_CHK: begin
        if (stat.ub_walk) begin
          cmd    = mk(OP_CALC, LST_FREE);
          st_nxt = S_WALK;
        end else begin
          cmd    = em(KIND_STATUS, ISEL_IN, ST_OK, 1'b0, 1'b1);
          st_nxt = S_IDLE;
        end
      end
      S_ST_CALC: begin
        cmd    = mk(OP_CALC, LST_FREE);
        st_nxt = S_WALK;
      end
      S_WALK: begin
        if (stat.walk_dummy) begin
          cmd    = mk(OP_SETDUMMY, LST_FREE);
          st_nxt = S_W_APP;
        end else if (!stat.walk_zero) begin
          cmd    = mk(OP_HEAD, LST_READY);
          st_nxt = S_W_UNL;
        end else begin
          st_nxt = S_IDLE;
          case (mode_r)
            MODE_QUEUE: cmd = em(KIND_STATUS, ISEL_ZERO,
                                 stat.walk_did ? ST_OK : ST_NONE, 1'b0, 1'b1);
            MODE_UNBLOCK: cmd = em(KIND_STATUS, ISEL_IN, ST_OK, 1'b0, 1'b1);
            default: cmd = em(KIND_STATUS, ISEL_ZERO, ST_OK, 1'b0, 1'b1);
          endcase
        end
      end
      S_W_UNL: begin
        cmd    = mk(OP_UNLINK, LST_READY);
        st_nxt = S_W_APP;
      end
      S_W_APP: begin
        cmd    = mk(OP_APPEND, LST_HOT);
        st_nxt = S_W_EMIT;
      end
      S_W_EMIT: begin
        cmd    = em(KIND_QUEUED, ISEL_NODE, ST_OK, 1'b0, 1'b0);
        cmd.op = OP_WALKDEC;
        st_nxt = S_WALK;
      end
      S_FIN_OK: begin
        cmd    = em(KIND_STATUS, ISEL_IN, ST_OK, 1'b0, 1'b1);
        st_nxt = S_IDLE;
      end
      S_FIN_NONE: begin
        cmd    = em(KIND_STATUS, ISEL_ZERO, ST_NONE, 1'b0, 1'b1);
        st_nxt = S_IDLE;
      end
      S_FIN_FD: begin
        cmd    = em(KIND_DONE, ISEL_NODE, ST_OK, 1'b1, 1'b1);
        st_nxt = S_IDLE;
      end
      S_FIN_BL: begin
        cmd    = em(KIND_BLOCKED, ISEL_NODE, ST_OK, 1'b0, 1'b1);
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      mode_r <= MODE_REGISTER;
    end else begin
      st_r   <= st_nxt;
      mode_r <= mode_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: design/dma_buffer_list_manager.sv
// Top level of the DMA buffer-list manager: controller plus datapath.
// Depends on dbl_pkg, dbl_ctrl, dbl_datapath and dbl_ram.
//
// Usage: an event request (in_mode, in_buffer_index, in_transfer_count,
// in_timestamp) is taken at a clock edge where start is high and busy is
// low. The block then works on that one request until its last result has
// been issued; busy stays high the whole time. Each result shows on the
// out_ ports for exactly one cycle with out_valid high, and out_last marks
// the closing result of the request. Queued-buffer results come first.
// The receiver cannot stall the block, so results are never held back.
// Configuration writes (cfg_valid, always ready) go to registers 0 to 2
// and are taken in any cycle. After reset the tag store is cleared, one
// slot a cycle, so busy stays high until all 64 slots are clear.
`timescale 1ns / 1ps
`default_nettype none
module dma_buffer_list_manager (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [5:0]  in_buffer_index,
  input  wire logic [31:0] in_transfer_count,
  input  wire logic [31:0] in_timestamp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  output logic             out_valid,
  output logic [1:0]       out_result_kind,
  output logic [6:0]       out_index,
  output logic [1:0]       out_status,
  output logic [31:0]      out_timestamp,
  output logic [6:0]       out_ready_now,
  output logic [6:0]       out_hot_now,
  output logic [31:0]      out_lost_now,
  output logic             out_last
);
  import dbl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  dbl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .stat(stat), .cmd(cmd), .busy(busy));

  dbl_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_buffer_index(in_buffer_index),
    .in_transfer_count(in_transfer_count), .in_timestamp(in_timestamp),
    .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat), .out_valid(out_valid),
    .out_result_kind(out_result_kind), .out_index(out_index),
    .out_status(out_status), .out_timestamp(out_timestamp),
    .out_ready_now(out_ready_now), .out_hot_now(out_hot_now),
    .out_lost_now(out_lost_now), .out_last(out_last));
endmodule
`default_nettype wire

FILE: design/dma_buffer_list_manager_checker.sv
// Port-level checks of the DMA buffer-list manager, bound to the top level.
// Depends on dma_buffer_list_manager_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dma_buffer_list_manager_defines.svh"
module dma_buffer_list_manager_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_result_kind,
  input wire logic       out_last
);
  localparam logic [1:0] KIND_QUEUED = 2'd1;

  `DBL_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "busy missing after request")
  `DBL_ASSERT(a_result_in_work, clk, rst_n, out_valid |-> $past(busy), "result outside a request")
  `DBL_ASSERT(a_last_gap, clk, rst_n, (out_valid && out_last) |=> !out_valid, "result after last")
  `DBL_ASSERT(a_nonlast_queued, clk, rst_n, (out_valid && !out_last) |-> (out_result_kind == KIND_QUEUED), "early result not queued")
endmodule

bind dma_buffer_list_manager dma_buffer_list_manager_checker u_chk (.*);
`default_nettype wire
